// ===== rtl/core/wlr_pkg.sv =====
// Shared types and constants for the weighted longest run per column block.
// No dependencies; imported by the lane, emitter and top-level modules.
package wlr_pkg;

    // Fixed field widths of the item channels
    localparam int ROW_W     = 32;
    localparam int LEN_W     = 20;
    localparam int TOT_W     = 25;
    localparam int IDX_OUT_W = 5;
    localparam int CFG_W     = 6;

    // Saturation limits and register reset value
    localparam logic [LEN_W-1:0] LEN_MAX   = {LEN_W{1'b1}};
    localparam logic [TOT_W-1:0] TOT_MAX   = {TOT_W{1'b1}};
    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    // Per-lane strobes from the row decoder
    typedef struct packed {
        logic step;  // row accepted and this cluster is in use
        logic set;   // this cluster contains the row
        logic last;  // row is the final one of the matrix
        logic clr;   // drop all run state after this row
    } t_lane_ctl;

endpackage

// ===== rtl/core/wlr_lane.sv =====
// One cluster lane: tracks the open run and the heaviest kept run.
// Depends on wlr_pkg for widths, saturation limit and the control struct.
module wlr_lane #(
    parameter int WEIGHT_BITS = 10,
    parameter int POS_W       = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  wlr_pkg::t_lane_ctl        i_ctl,
    input  logic [WEIGHT_BITS-1:0]    i_weight,
    input  logic [POS_W-1:0]          i_pos,
    input  logic [POS_W-1:0]          i_prev,
    output logic [wlr_pkg::LEN_W-1:0] o_kept_len,
    output logic [POS_W-1:0]          o_kept_start,
    output logic [POS_W-1:0]          o_kept_end
);
    import wlr_pkg::*;

    localparam int SUM_W = LEN_W + 1;

    logic [LEN_W-1:0] r_len, n_len;
    logic [POS_W-1:0] r_start, n_start;
    logic             r_in_run, n_in_run;
    logic [LEN_W-1:0] r_kept, n_kept;
    logic [POS_W-1:0] r_kstart, n_kstart;
    logic [POS_W-1:0] r_kend, n_kend;
    logic [SUM_W-1:0] w_sum;
    logic [LEN_W-1:0] w_len_sat;

    // Extend the open run, saturating at the length limit
    assign w_sum     = SUM_W'(r_len) + SUM_W'(i_weight);
    assign w_len_sat = w_sum[LEN_W] ? LEN_MAX : w_sum[LEN_W-1:0];

    // Advance the run; offer it to the kept slot when it closes
    always_comb begin
        n_len    = r_len;
        n_start  = r_start;
        n_in_run = r_in_run;
        n_kept   = r_kept;
        n_kstart = r_kstart;
        n_kend   = r_kend;
        if (i_ctl.step) begin
            if (i_ctl.set) begin
                n_len = w_len_sat;
                if (!r_in_run) begin
                    n_start  = i_pos;
                    n_in_run = 1'b1;
                end
                // final row closes the open run here
                if (i_ctl.last && (w_len_sat > r_kept)) begin
                    n_kept   = w_len_sat;
                    n_kstart = n_start;
                    n_kend   = i_pos;
                end
            end else if (r_in_run) begin
                if (r_len > r_kept) begin
                    n_kept   = r_len;
                    n_kstart = r_start;
                    n_kend   = i_prev;
                end
                n_len    = '0;
                n_in_run = 1'b0;
            end
        end
    end

    // Hold state; clear after the final row of a matrix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_len    <= '0;
            r_start  <= '0;
            r_in_run <= 1'b0;
            r_kept   <= '0;
            r_kstart <= '0;
            r_kend   <= '0;
        end else begin
            r_len    <= n_len;
            r_start  <= n_start;
            r_in_run <= n_in_run;
            r_kept   <= n_kept;
            r_kstart <= n_kstart;
            r_kend   <= n_kend;
        end
    end

    assign o_kept_len   = n_kept;
    assign o_kept_start = n_kstart;
    assign o_kept_end   = n_kend;

endmodule

// ===== rtl/core/wlr_emit.sv =====
// Merge stage: snapshots every lane's kept run and emits one item per cluster
// with a saturating running total. Depends on wlr_pkg for widths and limits.
module wlr_emit #(
    parameter int MAX_CLUSTERS = 32,
    parameter int POS_W        = 10,
    parameter int CNT_W        = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_capture,
    input  logic [CNT_W-1:0]              i_count,
    input  logic [wlr_pkg::LEN_W-1:0]     i_len   [MAX_CLUSTERS],
    input  logic [POS_W-1:0]              i_start [MAX_CLUSTERS],
    input  logic [POS_W-1:0]              i_end   [MAX_CLUSTERS],
    output logic                          o_busy,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [wlr_pkg::IDX_OUT_W-1:0] o_cluster_index,
    output logic [wlr_pkg::LEN_W-1:0]     o_best_length,
    output logic [POS_W-1:0]              o_best_start,
    output logic [POS_W-1:0]              o_best_end,
    output logic [wlr_pkg::TOT_W-1:0]     o_total_fitness,
    output logic                          o_last_result
);
    import wlr_pkg::*;

    localparam int IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int ACC_W = TOT_W + 1;

    logic [LEN_W-1:0] r_bank_len   [MAX_CLUSTERS];
    logic [POS_W-1:0] r_bank_start [MAX_CLUSTERS];
    logic [POS_W-1:0] r_bank_end   [MAX_CLUSTERS];
    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_count;
    logic [TOT_W-1:0] r_total;
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_idx;
    logic [LEN_W-1:0] r_out_len;
    logic [POS_W-1:0] r_out_start;
    logic [POS_W-1:0] r_out_end;
    logic [TOT_W-1:0] r_out_total;
    logic             r_out_last;

    logic             w_advance;
    logic             w_is_last;
    logic [ACC_W-1:0] w_acc;
    logic [TOT_W-1:0] w_total_sat;

    assign w_advance   = r_busy && (!r_out_valid || !i_out_stall);
    assign w_is_last   = (r_idx == IDX_W'(r_count - CNT_W'(1)));
    assign w_acc       = ACC_W'(r_total) + ACC_W'(r_bank_len[r_idx]);
    assign w_total_sat = w_acc[TOT_W] ? TOT_MAX : w_acc[TOT_W-1:0];

    // Snapshot the kept runs of all lanes on the final row
    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_bank_len   <= i_len;
            r_bank_start <= i_start;
            r_bank_end   <= i_end;
        end
    end

    // Walk the clusters in use, one item per cycle while the output is not stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= '0;
            r_count <= '0;
            r_total <= '0;
        end else if (i_capture) begin
            r_busy  <= 1'b1;
            r_idx   <= '0;
            r_count <= i_count;
            r_total <= '0;
        end else if (w_advance) begin
            r_total <= w_total_sat;
            if (w_is_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    // Output register: load on advance, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_idx   <= r_idx;
            r_out_len   <= r_bank_len[r_idx];
            r_out_start <= r_bank_start[r_idx];
            r_out_end   <= r_bank_end[r_idx];
            r_out_total <= w_total_sat;
            r_out_last  <= w_is_last;
        end
    end

    // Running total is registered alongside the item
    assign o_total_fitness = r_out_total;
    assign o_busy          = r_busy;
    assign o_out_valid     = r_out_valid;
    assign o_cluster_index = IDX_OUT_W'(r_out_idx);
    assign o_best_length   = r_out_len;
    assign o_best_start    = r_out_start;
    assign o_best_end      = r_out_end;
    assign o_last_result   = r_out_last;

endmodule

// ===== rtl/core/weighted_longest_run_per_column.sv =====
// Top level of the weighted longest run per column block.
// Depends on wlr_pkg, wlr_lane (one per cluster) and wlr_emit.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one matrix row per item:
//   membership bits, a weight and a last-row flag. Every cluster lane in use
//   updates its open and kept run in the cycle the row is accepted, so one
//   row is taken per cycle unless a last row is stalled as described below.
//   On the last row the kept runs of all lanes are copied into the output
//   bank and all run state clears; the next matrix may start the very next
//   cycle. The first result item is presented once the walk over the bank
//   has loaded the output register, then one item per cycle while the output
//   is not stalled, one per cluster in use in all, the final one flagged with
//   last_result and the whole fitness.
//   A further last row arriving while that burst is still draining is stalled
//   until the bank has been read out; other rows are never stalled.
//   Output channel (o_out_valid / i_out_stall): a stalled item holds, and the
//   burst pauses with it.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes cluster_count;
//   it is always ready.
//   Reset (synchronous, active low) clears all run state and sets
//   cluster_count to 32. There is no clearing pass.
module weighted_longest_run_per_column #(
    parameter int MAX_CLUSTERS = 32,
    parameter int MAX_ROWS     = 1024,
    parameter int WEIGHT_BITS  = 10
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // configuration
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [wlr_pkg::CFG_W-1:0]                i_cfg_data,
    // row items
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic [wlr_pkg::ROW_W-1:0]                i_row_bits,
    input  logic [WEIGHT_BITS-1:0]                   i_row_weight,
    input  logic                                     i_last_row,
    // result items
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic [wlr_pkg::IDX_OUT_W-1:0]            o_cluster_index,
    output logic [wlr_pkg::LEN_W-1:0]                o_best_length,
    output logic [$clog2(MAX_ROWS)-1:0]              o_best_start,
    output logic [$clog2(MAX_ROWS)-1:0]              o_best_end,
    output logic [wlr_pkg::TOT_W-1:0]                o_total_fitness,
    output logic                                     o_last_result
);
    import wlr_pkg::*;

    localparam int POS_W = $clog2(MAX_ROWS);
    localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);
    localparam int CMP_W = CFG_W + 1;

    logic [CFG_W-1:0] r_cluster_count;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] w_prev;
    logic [CMP_W-1:0] w_active;
    logic             w_accept;
    logic             w_capture;
    logic             w_busy;
    logic [LEN_W-1:0] w_len   [MAX_CLUSTERS];
    logic [POS_W-1:0] w_start [MAX_CLUSTERS];
    logic [POS_W-1:0] w_end   [MAX_CLUSTERS];

    // Configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_count <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cluster_count <= i_cfg_data;
        end
    end

    // Clusters in use: zero reads as one, clamp to the lane count
    always_comb begin
        if (r_cluster_count == '0) begin
            w_active = CMP_W'(1);
        end else if (CMP_W'(r_cluster_count) > CMP_W'(MAX_CLUSTERS)) begin
            w_active = CMP_W'(MAX_CLUSTERS);
        end else begin
            w_active = CMP_W'(r_cluster_count);
        end
    end

    // Hold a final row while the previous burst still drains
    assign o_in_stall = w_busy && i_in_valid && i_last_row;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_capture  = w_accept && i_last_row;

    // Row position, wrapping at the row limit
    assign w_prev = (r_pos == '0) ? POS_W'(MAX_ROWS - 1) : r_pos - POS_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_capture) begin
            r_pos <= '0;
        end else if (w_accept) begin
            r_pos <= (r_pos == POS_W'(MAX_ROWS - 1)) ? '0 : r_pos + POS_W'(1);
        end
    end

    // One lane per cluster
    for (genvar c = 0; c < MAX_CLUSTERS; c++) begin : g_lane
        t_lane_ctl w_ctl;
        logic      w_bit;

        if (c < ROW_W) begin : g_bit
            assign w_bit = i_row_bits[c];
        end else begin : g_nobit
            assign w_bit = 1'b0;
        end

        assign w_ctl.step = w_accept && (CMP_W'(c) < w_active);
        assign w_ctl.set  = w_bit;
        assign w_ctl.last = i_last_row;
        assign w_ctl.clr  = w_capture;

        wlr_lane #(
            .WEIGHT_BITS (WEIGHT_BITS),
            .POS_W       (POS_W)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_weight     (i_row_weight),
            .i_pos        (r_pos),
            .i_prev       (w_prev),
            .o_kept_len   (w_len[c]),
            .o_kept_start (w_start[c]),
            .o_kept_end   (w_end[c])
        );
    end

    // Merge the lanes into the result burst
    wlr_emit #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .POS_W        (POS_W),
        .CNT_W        (CNT_W)
    ) u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_capture       (w_capture),
        .i_count         (CNT_W'(w_active)),
        .i_len           (w_len),
        .i_start         (w_start),
        .i_end           (w_end),
        .o_busy          (w_busy),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cluster_index (o_cluster_index),
        .o_best_length   (o_best_length),
        .o_best_start    (o_best_start),
        .o_best_end      (o_best_end),
        .o_total_fitness (o_total_fitness),
        .o_last_result   (o_last_result)
    );

endmodule

// ===== sim/weighted_longest_run_per_column_tb.sv =====
// Self-checking testbench for weighted_longest_run_per_column: a directed table
// and random matrices, every result checked against a run-tracking predictor.
// Depends on wlr_pkg and the weighted_longest_run_per_column RTL only.
module weighted_longest_run_per_column_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wlr_pkg::*;

    localparam int CLUSTERS  = 32;
    localparam int POS_W     = 10;
    localparam int WGT_W     = 10;
    localparam int RAND_ROWS = 200;
    localparam int LONG_ROWS = 60;

    // One result item as the block emits it
    typedef struct packed {
        logic [IDX_OUT_W-1:0] idx;
        logic [LEN_W-1:0]     length;
        logic [POS_W-1:0]     start_pos;
        logic [POS_W-1:0]     end_pos;
        logic [TOT_W-1:0]     total;
        logic                 closing;
    } t_result;

    // One row of the directed table; the known_* fields give cluster 0's result
    typedef struct packed {
        logic             do_cfg;
        logic [CFG_W-1:0] cfg;
        logic [ROW_W-1:0] bits;
        logic [WGT_W-1:0] weight;
        logic             last;
        logic             known;
        logic [LEN_W-1:0] known_len;
        logic [POS_W-1:0] known_start;
        logic [POS_W-1:0] known_end;
        logic [TOT_W-1:0] known_total;
    } t_plan_row;

    localparam int PLAN_ROWS = 22;

    t_plan_row plan [PLAN_ROWS] = '{
        // reset setting: every cluster, heaviest weight, single-row matrix
        '{1'b0, 6'd0,  32'hFFFF_FFFF, 10'd1023, 1'b1, 1'b1, 20'd1023, 10'd0, 10'd0, 25'd1023},
        '{1'b0, 6'd0,  32'h0000_0000, 10'd1,    1'b1, 1'b1, 20'd0,    10'd0, 10'd0, 25'd0},
        // one cluster: equal runs, the earlier one stays
        '{1'b1, 6'd1,  32'h0000_0001, 10'd5,    1'b0, 1'b0, 20'd0,    10'd0, 10'd0, 25'd0},
        '{1'b0, 6'd0,  32'h0000_0001, 10'd7,    1'b0, 1'b0, 20'd0,    10'd0, 10'd0, 25'd0},
        '{1'b0, 6'd0,  32'h0000_0000, 10'd9,    1'b0, 1'b0, 20'd0,    10'd0, 10'd0, 25'd0},
        '{1'b0, 6'd0,  32'h0000_0001, 10'd12,   1'b1, 1'b1, 20'd12,   10'd0, 10'd1, 25'd12},
        // zero weight never makes a kept run
        '{1'b0, 6'd0,  32'h0000_0001, 10'd0,    1'b1, 1'b1, 20'd0,    10'd0, 10'd0, 25'd0},
        // run closed by a clear bit on the last row
        '{1'b0, 6'd0,  32'h0000_0000, 10'd4,    1'b0, 1'b0, 20'd0,    10'd0, 10'd0, 25'd0},
        '{1'b0, 6'd0,  32'h0000_0001, 10'd4,    1'b0, 1'b0, 20'd0,    10'd0, 10'd0, 25'd0},
        '{1'b0, 6'd0,  32'h0000_0001, 10'd0,    1'b0, 1'b0, 20'd0,    10'd0, 10'd0, 25'd0},
        '{1'b0, 6'd0,  32'h0000_0000, 10'd6,    1'b1, 1'b1, 20'd4,    10'd1, 10'd2, 25'd4},
        // count zero acts as one; bits above the count are ignored
        '{1'b1, 6'd0,  32'hFFFF_FFFE, 10'd1023, 1'b1, 1'b1, 20'd0,    10'd0, 10'd0, 25'd0},
        '{1'b0, 6'd0,  32'h0000_0001, 10'd3,    1'b1, 1'b1, 20'd3,    10'd0, 10'd0, 25'd3},
        // counts above the maximum saturate, then a count just below it
        '{1'b1, 6'd63, 32'hAAAA_AAAA, 10'd1,    1'b0, 1'b0, 20'd0,    10'd0, 10'd0, 25'd0},
        '{1'b0, 6'd0,  32'h5555_5555, 10'd2,    1'b0, 1'b0, 20'd0,    10'd0, 10'd0, 25'd0},
        '{1'b0, 6'd0,  32'hFFFF_FFFF, 10'd1023, 1'b1, 1'b0, 20'd0,    10'd0, 10'd0, 25'd0},
        '{1'b1, 6'd33, 32'h8000_0001, 10'd511,  1'b1, 1'b0, 20'd0,    10'd0, 10'd0, 25'd0},
        '{1'b1, 6'd31, 32'hC000_0000, 10'd1,    1'b0, 1'b0, 20'd0,    10'd0, 10'd0, 25'd0},
        '{1'b0, 6'd0,  32'h7FFF_FFFF, 10'd2,    1'b1, 1'b0, 20'd0,    10'd0, 10'd0, 25'd0},
        // two clusters, heavier first run wins
        '{1'b1, 6'd2,  32'h0000_0003, 10'd1023, 1'b0, 1'b0, 20'd0,    10'd0, 10'd0, 25'd0},
        '{1'b0, 6'd0,  32'h0000_0002, 10'd1,    1'b0, 1'b0, 20'd0,    10'd0, 10'd0, 25'd0},
        '{1'b0, 6'd0,  32'h0000_0001, 10'd1,    1'b1, 1'b1, 20'd1023, 10'd0, 10'd0, 25'd1023}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [ROW_W-1:0]     i_row_bits;
    logic [WGT_W-1:0]     i_row_weight;
    logic                 i_last_row;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [IDX_OUT_W-1:0] o_cluster_index;
    logic [LEN_W-1:0]     o_best_length;
    logic [POS_W-1:0]     o_best_start;
    logic [POS_W-1:0]     o_best_end;
    logic [TOT_W-1:0]     o_total_fitness;
    logic                 o_last_result;

    // Predictor state: open run and heaviest kept run per cluster
    logic [CFG_W-1:0] cluster_cfg;
    logic [LEN_W-1:0] open_len   [CLUSTERS];
    logic [POS_W-1:0] open_from  [CLUSTERS];
    logic             open_flag  [CLUSTERS];
    logic [LEN_W-1:0] best_len   [CLUSTERS];
    logic [POS_W-1:0] best_from  [CLUSTERS];
    logic [POS_W-1:0] best_to    [CLUSTERS];
    logic [POS_W-1:0] row_pos;

    t_result pending_results [$];
    t_result head;

    int failures;
    int rows_sent;
    int results_checked;
    int matrices_sent;
    int settings_used;
    int in_wait_max;
    int out_wait_max;

    weighted_longest_run_per_column #(
        .MAX_CLUSTERS (CLUSTERS),
        .MAX_ROWS     (1024),
        .WEIGHT_BITS  (WGT_W)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_row_bits      (i_row_bits),
        .i_row_weight    (i_row_weight),
        .i_last_row      (i_last_row),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cluster_index (o_cluster_index),
        .o_best_length   (o_best_length),
        .o_best_start    (o_best_start),
        .o_best_end      (o_best_end),
        .o_total_fitness (o_total_fitness),
        .o_last_result   (o_last_result)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Clusters in use for a register value
    function automatic int active_count(input logic [CFG_W-1:0] cfg);
        if (cfg == 0) begin
            return 1;
        end
        return (cfg > CLUSTERS) ? CLUSTERS : int'(cfg);
    endfunction

    function automatic int pick_wait(input int most);
        return (most == 0) ? 0 : $urandom_range(0, most);
    endfunction

    // Drop all run state, as after reset or a final burst
    task automatic clear_runs();
        for (int c = 0; c < CLUSTERS; c++) begin
            open_len[c]  = '0;
            open_from[c] = '0;
            open_flag[c] = 1'b0;
            best_len[c]  = '0;
            best_from[c] = '0;
            best_to[c]   = '0;
        end
        row_pos = '0;
    endtask

    // Keep the open run if strictly heavier than the kept one
    task automatic keep_heavier(input int c, input logic [POS_W-1:0] stop_pos);
        if (open_len[c] > best_len[c]) begin
            best_len[c]  = open_len[c];
            best_from[c] = open_from[c];
            best_to[c]   = stop_pos;
        end
    endtask

    // Advance the run state by one row; on the last row queue the burst
    task automatic track_row(input logic [ROW_W-1:0] bits, input logic [WGT_W-1:0] weight,
                             input logic last);
        int n;
        logic [POS_W-1:0] prev_pos;
        logic [LEN_W:0]   sum;
        logic [TOT_W:0]   total;
        t_result          r;
        n        = active_count(cluster_cfg);
        prev_pos = row_pos - 1'b1;
        for (int c = 0; c < n; c++) begin
            if (bits[c]) begin
                sum = {1'b0, open_len[c]} + weight;
                open_len[c] = (sum > LEN_MAX) ? LEN_MAX : sum[LEN_W-1:0];
                if (!open_flag[c]) begin
                    open_from[c] = row_pos;
                    open_flag[c] = 1'b1;
                end
                if (last) begin
                    keep_heavier(c, row_pos);
                end
            end else if (open_flag[c]) begin
                keep_heavier(c, prev_pos);
                open_len[c]  = '0;
                open_flag[c] = 1'b0;
            end
        end
        row_pos = row_pos + 1'b1;
        if (last) begin
            total = '0;
            for (int c = 0; c < n; c++) begin
                total = total + best_len[c];
                if (total > TOT_MAX) begin
                    total = {1'b0, TOT_MAX};
                end
                r.idx       = IDX_OUT_W'(c);
                r.length    = best_len[c];
                r.start_pos = best_from[c];
                r.end_pos   = best_to[c];
                r.total     = total[TOT_W-1:0];
                r.closing   = (c + 1 == n);
                pending_results.insert(pending_results.size(), r);
            end
            clear_runs();
            matrices_sent++;
        end
    endtask

    // Present one row after a random gap and hold it until taken
    task automatic send_row(input logic [ROW_W-1:0] bits, input logic [WGT_W-1:0] weight,
                            input logic last);
        int gap;
        gap = pick_wait(in_wait_max);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_row_bits   <= bits;
        i_row_weight <= weight;
        i_last_row   <= last;
        do @(posedge i_clk); while (o_in_stall);
        track_row(bits, weight, last);
        rows_sent++;
    endtask

    // Drop the row valid, then hold off until every expected result has come
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_in_valid  <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cluster_cfg = value;
        settings_used++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random row: the pattern mode shapes how long runs tend to be
    function automatic logic [ROW_W-1:0] make_bits(input int mode, input logic [ROW_W-1:0] prev);
        case (mode)
            0:       return $urandom();
            1:       return $urandom() | $urandom();
            2:       return $urandom() & $urandom() & $urandom();
            default: return prev ^ ($urandom() & $urandom() & $urandom());
        endcase
    endfunction

    function automatic logic [WGT_W-1:0] make_weight();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return WGT_W'($urandom());
            default: return WGT_W'($urandom_range(1, 15));
        endcase
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result item for cluster %0d with none expected", o_cluster_index);
                failures++;
            end else begin
                head = pending_results.pop_front();
                check_field("cluster_index", head.idx,       o_cluster_index);
                check_field("best_length",   head.length,    o_best_length);
                check_field("best_start",    head.start_pos, o_best_start);
                check_field("best_end",      head.end_pos,   o_best_end);
                check_field("total_fitness", head.total,     o_total_fitness);
                check_field("last_result",   head.closing,   o_last_result);
            end
            results_checked++;
        end
    end

    // Result side: stall a random number of cycles before each item
    initial begin
        int hold;
        @(posedge i_rst_n);
        forever begin
            hold = pick_wait(out_wait_max);
            repeat (hold) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Main sequence
    initial begin
        int idx;
        int rows;
        int mode;
        int random_rows;
        logic [ROW_W-1:0] bits;
        t_result typed;

        i_rst_n      <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_data   <= '0;
        i_in_valid   <= 1'b0;
        i_row_bits   <= '0;
        i_row_weight <= '0;
        i_last_row   <= 1'b0;
        i_out_stall  <= 1'b0;
        failures        = 0;
        rows_sent       = 0;
        results_checked = 0;
        matrices_sent   = 0;
        settings_used   = 1;
        in_wait_max     = 12;
        out_wait_max    = 12;
        cluster_cfg     = CFG_RESET;
        clear_runs();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; hand-typed values replace cluster 0's prediction
        for (int i = 0; i < PLAN_ROWS; i++) begin
            if (plan[i].do_cfg) begin
                write_count(plan[i].cfg);
            end
            send_row(plan[i].bits, plan[i].weight, plan[i].last);
            if (plan[i].known) begin
                idx   = pending_results.size() - active_count(cluster_cfg);
                typed = pending_results[idx];
                typed.length    = plan[i].known_len;
                typed.start_pos = plan[i].known_start;
                typed.end_pos   = plan[i].known_end;
                typed.total     = plan[i].known_total;
                pending_results[idx] = typed;
            end
        end

        // One longer matrix of heaviest rows, sent back to back
        write_count(6'd32);
        in_wait_max = 0;
        for (int i = 0; i < LONG_ROWS; i++) begin
            send_row(($urandom() | $urandom()) | 32'h1, '1, i == LONG_ROWS - 1);
        end

        // Random phases: new setting and idling style, then a few matrices
        random_rows = 0;
        while (random_rows < RAND_ROWS) begin
            case ($urandom_range(0, 7))
                0:       write_count(6'd0);
                1:       write_count(6'd1);
                2:       write_count(6'd2);
                3:       write_count(6'd31);
                4:       write_count(6'd32);
                5:       write_count(6'd33);
                6:       write_count(6'd63);
                default: write_count(CFG_W'($urandom_range(0, 63)));
            endcase
            in_wait_max  = ($urandom_range(0, 3) == 0) ? 0 : 12;
            out_wait_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            repeat ($urandom_range(2, 6)) begin
                rows = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20)
                                                   : $urandom_range(1, 8);
                mode = $urandom_range(0, 3);
                bits = $urandom();
                for (int r = 0; r < rows; r++) begin
                    bits = make_bits(mode, bits);
                    send_row(bits, make_weight(), r == rows - 1);
                end
                random_rows += rows;
                // now and then let the whole burst drain before the next matrix
                if ($urandom_range(0, 4) == 0) begin
                    wait_drained();
                end
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d rows in %0d matrices over %0d register settings;",
                 rows_sent, matrices_sent, settings_used);
        $display("checked %0d result items, %0d mismatches.", results_checked, failures);
        if (failures == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #5_000_000;
        $display("Timed out with %0d results still expected", pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
